### design/adc_trimmed_mean_monitor_assert.svh
// Assertion macros used by the trimmed-mean monitor RTL.
`ifndef ADC_TRIMMED_MEAN_MONITOR_ASSERT_SVH
`define ADC_TRIMMED_MEAN_MONITOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ATMM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ATMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/atmm_pkg.sv
// Shared types and constants of the trimmed-mean ADC monitor.
package atmm_pkg;

    // Field widths
    localparam int SAMPLE_W   = 12;
    localparam int SUM_W      = 18;
    localparam int CUR_W      = 17;
    localparam int VOLT_W     = 14;
    localparam int OFFSET_W   = 20;
    localparam int CGAIN_W    = 16;
    localparam int VGAIN_W    = 18;
    localparam int TICK_SUM_W = 20;
    localparam int IN_CH      = 4;

    // Stream and configuration port widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 112;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;

    typedef logic [SAMPLE_W-1:0]     t_sample;
    typedef logic [SUM_W-1:0]        t_sum;
    typedef logic signed [CUR_W-1:0] t_current;
    typedef logic [VOLT_W-1:0]       t_volt;
    typedef logic [OFFSET_W-1:0]     t_offset;
    typedef logic [CGAIN_W-1:0]      t_cgain;
    typedef logic [VGAIN_W-1:0]      t_vgain;
    typedef logic [CFG_IDX_W-1:0]    t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]   t_cfg_data;

    // Register indexes
    localparam t_cfg_idx CFG_CUR_OFFSET = 2'd0;
    localparam t_cfg_idx CFG_CUR_GAIN   = 2'd1;
    localparam t_cfg_idx CFG_VOLT_GAIN  = 2'd2;
    localparam t_cfg_idx CFG_SUP_FLOOR  = 2'd3;

    // Calibration defaults
    localparam t_offset RST_CUR_OFFSET = 20'd226986;
    localparam t_cgain  RST_CUR_GAIN   = 16'd3699;
    localparam t_vgain  RST_VOLT_GAIN  = 18'd148710;
    localparam t_volt   RST_SUP_FLOOR  = 14'd2560;

    // Current saturation limits
    localparam t_current CUR_MAX = 17'sd65535;
    localparam t_current CUR_MIN = -17'sd65536;

    // Input item kind
    localparam logic MODE_SET  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Per-lane control from the pipeline sequencer
    typedef struct packed {
        logic sample;     // sample set accepted this cycle
        logic first;      // first set of a batch
        logic load_mean;  // trimmed sum moves into the mean stage
    } t_lane_ctl;

endpackage

### design/atmm_lane.sv
// One channel lane: running max/min/sum and the trimmed-mean divider.
module atmm_lane #(
    parameter int SAMPLES = 10
) (
    input  logic                i_clk,
    input  atmm_pkg::t_lane_ctl i_ctl,
    input  atmm_pkg::t_sample   i_sample,
    output atmm_pkg::t_sample   o_mean
);
    import atmm_pkg::*;

    // Exact floor division by SAMPLES-2 over the whole sum range
    localparam int DIV     = SAMPLES - 2;
    localparam int DIV_LOG = $clog2(DIV);
    localparam int SHIFT   = SUM_W + DIV_LOG;
    localparam int REC_W   = SUM_W + 1;
    localparam int PROD_W  = SUM_W + REC_W;
    localparam longint unsigned REC_L =
        ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [REC_W-1:0] REC = REC_W'(REC_L);

    t_sample             r_max, r_min, r_mean;
    t_sum                r_sum, r_trim;
    t_sample             n_max, n_min;
    t_sum                n_sum, n_trim;
    logic [PROD_W-1:0]   w_prod;

    // Running statistics with the incoming set folded in
    always_comb begin
        if (i_ctl.first) begin
            n_max = i_sample;
            n_min = i_sample;
            n_sum = SUM_W'(i_sample);
        end else begin
            n_max = (i_sample > r_max) ? i_sample : r_max;
            n_min = (i_sample < r_min) ? i_sample : r_min;
            n_sum = r_sum + SUM_W'(i_sample);
        end
        n_trim = n_sum - SUM_W'(n_max) - SUM_W'(n_min);
    end

    // Reciprocal multiply, quotient taken from the upper bits
    assign w_prod = PROD_W'(r_trim) * PROD_W'(REC);

    always_ff @(posedge i_clk) begin
        if (i_ctl.sample) begin
            r_max  <= n_max;
            r_min  <= n_min;
            r_sum  <= n_sum;
            r_trim <= n_trim;
        end
        if (i_ctl.load_mean) begin
            r_mean <= w_prod[SHIFT +: SAMPLE_W];
        end
    end

    assign o_mean = r_mean;

endmodule

### design/atmm_scale.sv
// Merge stage: calibrated currents and bus voltage from the lane means.
module atmm_scale (
    input  logic               i_clk,
    input  logic               i_load,
    input  atmm_pkg::t_sample  i_mean_a,
    input  atmm_pkg::t_sample  i_mean_b,
    input  atmm_pkg::t_sample  i_mean_v,
    input  atmm_pkg::t_offset  i_offset,
    input  atmm_pkg::t_cgain   i_cgain,
    input  atmm_pkg::t_vgain   i_vgain,
    output atmm_pkg::t_current o_cur_a,
    output atmm_pkg::t_current o_cur_b,
    output atmm_pkg::t_volt    o_bus
);
    import atmm_pkg::*;

    localparam int DIFF_W  = SAMPLE_W + 8 + 1;
    localparam int PRODC_W = DIFF_W + CGAIN_W + 1;
    localparam int QW      = PRODC_W - 16;
    localparam int VPROD_W = SAMPLE_W + VGAIN_W;

    t_current          r_cur_a, r_cur_b;
    t_volt             r_bus;
    logic [VPROD_W-1:0] w_vprod;

    // (mean*256 - offset) * gain, floored Q16 shift, clipped to 17 bits
    function automatic t_current scale_cur(t_sample mean, t_offset off, t_cgain gain);
        logic signed [DIFF_W-1:0]  diff;
        logic signed [PRODC_W-1:0] prod;
        logic signed [QW-1:0]      q;
        diff = $signed({1'b0, mean, 8'b0}) - $signed({1'b0, off});
        prod = PRODC_W'(diff) * PRODC_W'($signed({1'b0, gain}));
        q    = prod[PRODC_W-1:16];
        if (q > QW'(CUR_MAX)) begin
            scale_cur = CUR_MAX;
        end else if (q < QW'(CUR_MIN)) begin
            scale_cur = CUR_MIN;
        end else begin
            scale_cur = q[CUR_W-1:0];
        end
    endfunction

    // Bus voltage never exceeds the 14-bit range for 12-bit codes
    assign w_vprod = VPROD_W'(i_mean_v) * VPROD_W'(i_vgain);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cur_a <= scale_cur(i_mean_a, i_offset, i_cgain);
            r_cur_b <= scale_cur(i_mean_b, i_offset, i_cgain);
            r_bus   <= w_vprod[VPROD_W-1:16];
        end
    end

    assign o_cur_a = r_cur_a;
    assign o_cur_b = r_cur_b;
    assign o_bus   = r_bus;

endmodule

### design/atmm_supply.sv
// Supply-voltage averager over a window of one-second ticks.
module atmm_supply #(
    parameter int WINDOW_TICKS = 60
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tick,
    input  atmm_pkg::t_volt i_bus,
    input  atmm_pkg::t_volt i_floor,
    output atmm_pkg::t_volt o_supply
);
    import atmm_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW_TICKS + 1);
    localparam int W_LOG  = $clog2(WINDOW_TICKS);
    localparam int SHIFT  = TICK_SUM_W + W_LOG;
    localparam int REC_W  = TICK_SUM_W + 1;
    localparam int PROD_W = TICK_SUM_W + REC_W;
    localparam longint unsigned REC_L =
        ((64'd1 << SHIFT) + 64'(WINDOW_TICKS) - 64'd1) / 64'(WINDOW_TICKS);
    localparam logic [REC_W-1:0] REC = REC_W'(REC_L);

    logic [TICK_SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    t_volt                 r_supply, w_keep;
    logic                  w_wrap;
    logic [PROD_W-1:0]     w_prod;

    // Accumulate, detect the end of the window, and pick the bus voltage for a supply below the floor
    always_comb begin
        n_sum  = r_sum + TICK_SUM_W'(i_bus);
        n_cnt  = r_cnt + 1'b1;
        w_wrap = (n_cnt == CNT_W'(WINDOW_TICKS));
        w_keep = (r_supply < i_floor) ? i_bus : r_supply;
    end

    // Window average by reciprocal multiply
    assign w_prod = PROD_W'(n_sum) * PROD_W'(REC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_cnt    <= '0;
            r_supply <= '0;
        end else if (i_tick) begin
            if (w_wrap) begin
                r_supply <= w_prod[SHIFT +: VOLT_W];
                r_sum    <= '0;
                r_cnt    <= '0;
            end else begin
                r_supply <= w_keep;
                r_sum    <= n_sum;
                r_cnt    <= n_cnt;
            end
        end
    end

    assign o_supply = r_supply;

endmodule

### design/adc_trimmed_mean_monitor.sv
// Trimmed-mean ADC monitor: per-channel lanes, calibrated scaling, supply average.
// A result passes the lane update, reciprocal divide, scaling multiply and held-result
// register stages in that order after the edge that accepts its input transaction.
// Throughput: one item per cycle while the result stream is ready; the four stages are fully pipelined.
// Reset (synchronous, active low): empties the pipeline, clears counters and held
// results, and reloads the calibration registers with their defaults.
`include "adc_trimmed_mean_monitor_assert.svh"

module adc_trimmed_mean_monitor #(
    parameter int SAMPLES      = 10,
    parameter int CHANNELS     = 4,
    parameter int WINDOW_TICKS = 60
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: raw_ch0, raw_ch1, raw_ch2, raw_ch3
    input  logic [atmm_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // tuser: mode
    input  logic                                i_s_axis_tuser,
    // Result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: mean_ch0, mean_ch1, mean_ch2, mean_ch3, current_a, current_b,
    //        bus_voltage, supply_level, 2 zero bits
    output logic [atmm_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // tuser: batch_done
    output logic                                o_m_axis_tuser,
    // Configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  atmm_pkg::t_cfg_idx                  i_cfg_index,
    input  atmm_pkg::t_cfg_data                 i_cfg_data
);
    import atmm_pkg::*;

    localparam int CNT_W = $clog2(SAMPLES);
    localparam logic [CNT_W-1:0] LAST_SET = CNT_W'(SAMPLES - 1);

    // Calibration registers
    t_offset r_cur_offset;
    t_cgain  r_cur_gain;
    t_vgain  r_volt_gain;
    t_volt   r_sup_floor;

    // Pipeline control
    logic             r_v1, r_v2, r_v3, r_out_valid;
    logic             r_mode1, r_mode2, r_mode3;
    logic             r_done1, r_done2, r_done3;
    logic [CNT_W-1:0] r_set_count;
    logic             w_acc, w_set, w_go1, w_go2, w_go3, w_last;
    t_lane_ctl        w_ctl;

    // Lane and merge data
    t_sample  w_lane_mean [CHANNELS];
    t_sample  w_mean      [IN_CH];
    t_sample  r_mean3     [IN_CH];
    t_current w_cur_a, w_cur_b;
    t_volt    w_bus;

    // Held results
    t_sample  r_out_mean [IN_CH];
    t_current r_out_cur_a, r_out_cur_b;
    t_volt    r_out_bus;
    t_volt    w_supply;
    logic     r_out_done;
    logic     r_seen;

    // Configuration write port, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_offset <= RST_CUR_OFFSET;
            r_cur_gain   <= RST_CUR_GAIN;
            r_volt_gain  <= RST_VOLT_GAIN;
            r_sup_floor  <= RST_SUP_FLOOR;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CUR_OFFSET: r_cur_offset <= i_cfg_data[OFFSET_W-1:0];
                CFG_CUR_GAIN:   r_cur_gain   <= i_cfg_data[CGAIN_W-1:0];
                CFG_VOLT_GAIN:  r_volt_gain  <= i_cfg_data[VGAIN_W-1:0];
                CFG_SUP_FLOOR:  r_sup_floor  <= i_cfg_data[VOLT_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage handshakes: each stage moves when the next one is free or moving
    always_comb begin
        w_go3           = r_v3 && (!r_out_valid || i_m_axis_tready);
        w_go2           = r_v2 && (!r_v3 || w_go3);
        w_go1           = r_v1 && (!r_v2 || w_go2);
        o_s_axis_tready = !r_v1 || w_go1;
        w_acc           = i_s_axis_tvalid && o_s_axis_tready;
        w_set           = w_acc && (i_s_axis_tuser == MODE_SET);
        w_last          = (r_set_count == LAST_SET);
        w_ctl.sample    = w_set;
        w_ctl.first     = (r_set_count == '0);
        w_ctl.load_mean = w_go1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
            r_set_count <= '0;
        end else begin
            if (w_acc) begin
                r_v1 <= 1'b1;
            end else if (w_go1) begin
                r_v1 <= 1'b0;
            end
            if (w_go1) begin
                r_v2 <= 1'b1;
            end else if (w_go2) begin
                r_v2 <= 1'b0;
            end
            if (w_go2) begin
                r_v3 <= 1'b1;
            end else if (w_go3) begin
                r_v3 <= 1'b0;
            end
            if (w_go3) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_set) begin
                r_set_count <= w_last ? '0 : r_set_count + 1'b1;
            end
        end
    end

    // Item kind and batch flag travel alongside the lane data
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mode1 <= i_s_axis_tuser;
            r_done1 <= w_set && w_last;
        end
        if (w_go1) begin
            r_mode2 <= r_mode1;
            r_done2 <= r_done1;
        end
        if (w_go2) begin
            r_mode3 <= r_mode2;
            r_done3 <= r_done2;
        end
    end

    // Channel lanes; lanes past the input channels see zero
    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        t_sample w_sample;
        if (c < IN_CH) begin : g_in
            assign w_sample = i_s_axis_tdata[c*SAMPLE_W +: SAMPLE_W];
        end else begin : g_zero
            assign w_sample = '0;
        end
        atmm_lane #(
            .SAMPLES (SAMPLES)
        ) u_lane (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_sample (w_sample),
            .o_mean   (w_lane_mean[c])
        );
    end

    // Reported channels; unconfigured ones read as zero
    for (genvar c = 0; c < IN_CH; c++) begin : g_mean
        if (c < CHANNELS) begin : g_used
            assign w_mean[c] = w_lane_mean[c];
        end else begin : g_unused
            assign w_mean[c] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go2) begin
            r_mean3 <= w_mean;
        end
    end

    atmm_scale u_scale (
        .i_clk    (i_clk),
        .i_load   (w_go2),
        .i_mean_a (w_mean[0]),
        .i_mean_b (w_mean[1]),
        .i_mean_v (w_mean[2]),
        .i_offset (r_cur_offset),
        .i_cgain  (r_cur_gain),
        .i_vgain  (r_volt_gain),
        .o_cur_a  (w_cur_a),
        .o_cur_b  (w_cur_b),
        .o_bus    (w_bus)
    );

    // Held results double as the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_done  <= 1'b0;
            r_seen      <= 1'b0;
            r_out_cur_a <= '0;
            r_out_cur_b <= '0;
            r_out_bus   <= '0;
            for (int i = 0; i < IN_CH; i++) begin
                r_out_mean[i] <= '0;
            end
        end else if (w_go3) begin
            r_out_done <= r_done3;
            if (r_done3) begin
                r_seen      <= 1'b1;
                r_out_mean  <= r_mean3;
                r_out_cur_a <= w_cur_a;
                r_out_cur_b <= w_cur_b;
                r_out_bus   <= w_bus;
            end
        end
    end

    // Ticks count only once a batch has been seen
    atmm_supply #(
        .WINDOW_TICKS (WINDOW_TICKS)
    ) u_supply (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (w_go3 && (r_mode3 == MODE_TICK) && r_seen),
        .i_bus    (r_out_bus),
        .i_floor  (r_sup_floor),
        .o_supply (w_supply)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_done;
    assign o_m_axis_tdata  = {2'b00, w_supply, r_out_bus, r_out_cur_b, r_out_cur_a,
                              r_out_mean[3], r_out_mean[2], r_out_mean[1], r_out_mean[0]};

    // Checks
    `ATMM_ASSERT_SAME(a_done_after_seen, i_clk, i_rst_n, r_out_valid && r_out_done, r_seen, "batch flag without a completed batch")
    `ATMM_ASSERT_SAME(a_tick_not_done, i_clk, i_rst_n, r_v1 && (r_mode1 == MODE_TICK), !r_done1, "tick marked as batch end")
    `ATMM_ASSERT_NEXT(a_batch_wrap, i_clk, i_rst_n, w_set && w_last, r_done1 && (r_set_count == '0), "set counter did not close the batch")
    `ATMM_ASSERT_NEXT(a_out_fill, i_clk, i_rst_n, r_v3 && !r_out_valid, r_out_valid, "result stage did not move to an empty output")

endmodule

### verif/tb_adc_trimmed_mean_monitor.sv
// Self-checking testbench for the trimmed-mean ADC monitor: directed table, then random traffic.
module tb_adc_trimmed_mean_monitor;
    timeunit 1ns;
    timeprecision 1ps;

    import atmm_pkg::*;

    localparam int SAMPLES      = 10;
    localparam int CHANNELS     = 4;
    localparam int WINDOW_TICKS = 60;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 230;
    localparam int LONG_HOLD    = 250;
    localparam int CYCLE_LIMIT  = 500000;

    // One result item, as predicted or as observed
    typedef struct packed {
        logic              done;
        t_sample [3:0]     mean;
        t_current          cur_a;
        t_current          cur_b;
        t_volt             bus;
        t_volt             supply;
    } monitor_result_t;

    typedef struct {
        logic            mode;
        logic [47:0]     data;
        bit              typed;
        monitor_result_t want;
    } stim_row_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   i_s_axis_tuser = MODE_SET;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    t_cfg_idx               i_cfg_index = CFG_CUR_OFFSET;
    t_cfg_data              i_cfg_data = '0;

    adc_trimmed_mean_monitor #(
        .SAMPLES      (SAMPLES),
        .CHANNELS     (CHANNELS),
        .WINDOW_TICKS (WINDOW_TICKS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Calibration as the block should hold it
    t_offset cal_offset = RST_CUR_OFFSET;
    t_cgain  cal_cgain  = RST_CUR_GAIN;
    t_vgain  cal_vgain  = RST_VOLT_GAIN;
    t_volt   cal_floor  = RST_SUP_FLOOR;

    // Mirror of the monitor state
    int            sets_in_batch = 0;
    t_sample       acc_max [CHANNELS];
    t_sample       acc_min [CHANNELS];
    t_sum          acc_sum [CHANNELS];
    t_sample [3:0] mean_hold = '0;
    t_current      amps_a_hold = '0;
    t_current      amps_b_hold = '0;
    t_volt         bus_hold = '0;
    bit            batch_seen = 1'b0;
    t_volt         supply_hold = '0;
    logic [TICK_SUM_W-1:0] window_sum = '0;
    int            window_ticks = 0;

    monitor_result_t pending_results [$];
    int  error_count    = 0;
    int  accepted_items = 0;
    int  cycle_count    = 0;
    bit  idle_on        = 1'b1;
    bit  long_hold_done = 1'b0;

    // Q8 amperes from a mean code, floored, saturated to 17 bits
    function automatic t_current q8_current(input t_sample code);
        longint diff;
        longint prod;
        longint q;
        diff = longint'(code) * 256 - longint'(cal_offset);
        prod = diff * longint'(cal_cgain);
        q    = prod >>> 16;
        if (q > 65535)  q = 65535;
        if (q < -65536) q = -65536;
        return q[CUR_W-1:0];
    endfunction

    // Q8 volts from a mean code
    function automatic t_volt q8_voltage(input t_sample code);
        longint v;
        v = (longint'(code) * longint'(cal_vgain)) >> 16;
        if (v > 16383) v = 16383;
        return v[VOLT_W-1:0];
    endfunction

    // Advance the mirrored state by one accepted item and form its result
    task automatic predict_monitor_result(input logic mode, input logic [47:0] data,
                                          output monitor_result_t res);
        t_sample code;
        t_sum    trimmed;
        bit      done;
        done = 1'b0;
        if (mode == MODE_SET) begin
            for (int c = 0; c < CHANNELS; c++) begin
                code = data[12*c +: 12];
                if (sets_in_batch == 0) begin
                    acc_max[c] = code;
                    acc_min[c] = code;
                    acc_sum[c] = t_sum'(code);
                end else begin
                    if (code > acc_max[c]) acc_max[c] = code;
                    if (code < acc_min[c]) acc_min[c] = code;
                    acc_sum[c] = acc_sum[c] + t_sum'(code);
                end
            end
            sets_in_batch++;
            if (sets_in_batch >= SAMPLES) begin
                sets_in_batch = 0;
                for (int c = 0; c < CHANNELS; c++) begin
                    trimmed      = acc_sum[c] - acc_max[c] - acc_min[c];
                    mean_hold[c] = t_sample'(trimmed / (SAMPLES - 2));
                end
                amps_a_hold = q8_current(mean_hold[0]);
                amps_b_hold = q8_current(mean_hold[1]);
                bus_hold    = q8_voltage(mean_hold[2]);
                batch_seen  = 1'b1;
                done        = 1'b1;
            end
        end else if (batch_seen) begin
            // one-second tick: low supply is overwritten, then the window advances
            if (supply_hold < cal_floor) supply_hold = bus_hold;
            window_sum = window_sum + TICK_SUM_W'(bus_hold);
            window_ticks++;
            if (window_ticks >= WINDOW_TICKS) begin
                supply_hold  = t_volt'(window_sum / WINDOW_TICKS);
                window_sum   = '0;
                window_ticks = 0;
            end
        end
        res.done   = done;
        res.mean   = mean_hold;
        res.cur_a  = amps_a_hold;
        res.cur_b  = amps_b_hold;
        res.bus    = bus_hold;
        res.supply = supply_hold;
    endtask

    // Offer one item; expectation is queued at the accepting edge
    task automatic send_item(input logic mode, input logic [47:0] data,
                             input bit typed, input monitor_result_t want);
        int              gap;
        monitor_result_t res;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= mode;
        i_s_axis_tdata  <= data;
        do @(negedge i_clk); while (!o_s_axis_tready);
        @(posedge i_clk);
        predict_monitor_result(mode, data, res);
        pending_results.push_back(typed ? want : res);
        accepted_items++;
    endtask

    // One register write transaction
    task automatic write_register(input t_cfg_idx idx, input t_cfg_data value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        case (idx)
            CFG_CUR_OFFSET: cal_offset = value[OFFSET_W-1:0];
            CFG_CUR_GAIN:   cal_cgain  = value[CGAIN_W-1:0];
            CFG_VOLT_GAIN:  cal_vgain  = value[VGAIN_W-1:0];
            CFG_SUP_FLOOR:  cal_floor  = value[VOLT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_calibration(input t_offset offs, input t_cgain cg,
                                     input t_vgain vg, input t_volt flr);
        write_register(CFG_CUR_OFFSET, t_cfg_data'(offs));
        write_register(CFG_CUR_GAIN,   t_cfg_data'(cg));
        write_register(CFG_VOLT_GAIN,  t_cfg_data'(vg));
        write_register(CFG_SUP_FLOOR,  t_cfg_data'(flr));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Result receiver: random stalls, plus one long hold-off to back the pipe up
    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && accepted_items >= 400) begin
                i_m_axis_tready <= 1'b0;
                for (int k = 0; k < LONG_HOLD; k++) @(posedge i_clk);
                long_hold_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                stall = $urandom_range(1, 18);
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
        end
    end

    // Result checker: handshake sampled mid-cycle, transaction lands at the next edge
    monitor_result_t want_res;
    t_current        got_a;
    t_current        got_b;
    always @(negedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no expectation pending");
                error_count++;
            end else begin
                want_res = pending_results.pop_front();
                got_a    = o_m_axis_tdata[48 +: CUR_W];
                got_b    = o_m_axis_tdata[65 +: CUR_W];
                check_field("batch_done", want_res.done, o_m_axis_tuser);
                for (int c = 0; c < 4; c++)
                    check_field($sformatf("mean_ch%0d", c), want_res.mean[c],
                                o_m_axis_tdata[12*c +: 12]);
                check_field("current_a", $signed(want_res.cur_a), $signed(got_a));
                check_field("current_b", $signed(want_res.cur_b), $signed(got_b));
                check_field("bus_voltage", want_res.bus, o_m_axis_tdata[82 +: VOLT_W]);
                check_field("supply_level", want_res.supply,
                            o_m_axis_tdata[96 +: VOLT_W]);
                check_field("tdata_pad", 0, o_m_axis_tdata[110 +: 2]);
            end
        end
    end

    // Run limit
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        stim_row_t       directed [$];
        stim_row_t       row;
        monitor_result_t zero_res;
        monitor_result_t none;
        logic [47:0]     data;
        logic [63:0]     noise;
        t_sample         centre [4];
        int              v;
        int              sets_sent;

        zero_res  = '0;
        none      = '0;
        sets_sent = 0;

        // Directed table: tick before any batch leaves everything at zero
        directed.push_back('{MODE_TICK, 48'hFFFF_FFFF_FFFF, 1'b1, zero_res});
        // All-zero batch: means zero, currents at the negative end of the default scale
        for (int k = 0; k < SAMPLES; k++) begin
            row = '{MODE_SET, 48'd0, 1'b0, none};
            if (k == SAMPLES - 1) begin
                row.typed      = 1'b1;
                row.want       = zero_res;
                row.want.done  = 1'b1;
                row.want.cur_a = -17'sd12812;
                row.want.cur_b = -17'sd12812;
            end
            directed.push_back(row);
        end
        // Tick after the first batch: supply below the floor takes the bus voltage
        directed.push_back('{MODE_TICK, 48'd0, 1'b0, none});
        // Batch at full scale on channel 0, moving extremes on the others
        for (int k = 0; k < SAMPLES; k++) begin
            data[11:0]  = 12'hFFF;
            data[23:12] = 12'(k * 455);
            data[35:24] = 12'(4095 - k * 400);
            data[47:36] = (k % 2) ? 12'hFFF : 12'h000;
            directed.push_back('{MODE_SET, data, 1'b0, none});
        end
        directed.push_back('{MODE_TICK, 48'd0, 1'b0, none});
        directed.push_back('{MODE_TICK, 48'hA5A5_5A5A_F00F, 1'b0, none});

        // Reset: hold low, then release
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_item(directed[i].mode, directed[i].data, directed[i].typed, directed[i].want);
        i_s_axis_tvalid <= 1'b0;

        // Random phases, each under its own calibration
        for (int phase = 0; phase < PHASES; phase++) begin
            while (pending_results.size() != 0) @(posedge i_clk);
            idle_on = (phase != PHASES - 1);
            case (phase)
                0: apply_calibration(20'hFFFFF, 16'hFFFF, 18'h3FFFF, 14'd9293);
                1: apply_calibration('0, '0, '0, '0);
                2: apply_calibration('0, 16'hFFFF, t_vgain'($urandom_range(0, 262143)),
                                     t_volt'($urandom_range(0, 9293)));
                PHASES - 1: apply_calibration(RST_CUR_OFFSET, RST_CUR_GAIN,
                                              RST_VOLT_GAIN, RST_SUP_FLOOR);
                default: apply_calibration(t_offset'($urandom_range(0, 1048575)),
                                           t_cgain'($urandom_range(0, 65535)),
                                           t_vgain'($urandom_range(0, 262143)),
                                           t_volt'($urandom_range(0, 9293)));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 30) begin
                    // tick: channel codes are don't-care, send noise
                    noise = {$urandom, $urandom};
                    send_item(MODE_TICK, noise[47:0], 1'b0, none);
                end else begin
                    // fresh operating point per batch, jitter around it
                    if (sets_sent % SAMPLES == 0)
                        for (int c = 0; c < 4; c++)
                            centre[c] = t_sample'($urandom_range(0, 4095));
                    for (int c = 0; c < 4; c++) begin
                        case ($urandom_range(0, 9))
                            0:       v = 0;
                            1:       v = 4095;
                            2, 3, 4: v = $urandom_range(0, 4095);
                            default: v = int'(centre[c]) + int'($urandom_range(0, 64)) - 32;
                        endcase
                        if (v < 0)    v = 0;
                        if (v > 4095) v = 4095;
                        data[12*c +: 12] = v[11:0];
                    end
                    send_item(MODE_SET, data, 1'b0, none);
                    sets_sent++;
                end
            end
            i_s_axis_tvalid <= 1'b0;
        end

        // Drain, then wait for anything stray
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
